// File: rtl/jbp_pkg.sv
`default_nettype none

package jbp_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 8;
  localparam int TAG_BITS    = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int STREAM_W = 32;
  localparam int SEQ_W    = 32;
  localparam int CMD_W    = 2;
  localparam int EV_W     = 3;
  localparam int THR_W    = 4;
  localparam int LATE_W   = 4;
  localparam int FILL_W   = 4;

  // Packed stream words, rounded up to whole bytes
  localparam int IN_BITS    = STREAM_W + SEQ_W + TAG_BITS;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = TAG_BITS + STREAM_W + SEQ_W + LATE_W + FILL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

  // Result events
  localparam logic [EV_W-1:0] EV_QUEUED  = 3'd0;
  localparam logic [EV_W-1:0] EV_DROPPED = 3'd1;
  localparam logic [EV_W-1:0] EV_PRIMING = 3'd2;
  localparam logic [EV_W-1:0] EV_PLAY    = 3'd3;
  localparam logic [EV_W-1:0] EV_SILENCE = 3'd4;
  localparam logic [EV_W-1:0] EV_FLUSHED = 3'd5;

  // Frame descriptor as stored in the queue
  typedef struct packed {
    logic [STREAM_W-1:0] stream;
    logic [SEQ_W-1:0]    seq;
    logic [TAG_BITS-1:0] tag;
  } jbp_desc_t;

endpackage

`default_nettype wire

// File: rtl/jbp_desc_ram.sv
`default_nettype none

module jbp_desc_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [jbp_pkg::PTR_W-1:0] waddr,
  input  wire jbp_pkg::jbp_desc_t        wdata,
  input  wire logic                      re,
  input  wire logic [jbp_pkg::PTR_W-1:0] raddr,
  output jbp_pkg::jbp_desc_t             rdata
);
  import jbp_pkg::*;

  jbp_desc_t mem [QUEUE_DEPTH];

  // Write one descriptor
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/jitter_buffer_playout_core.sv
`default_nettype none

// Frame jitter buffer with playout sequencer. Command arrive (tuser 0) queues a frame
// descriptor into an 8-entry queue or reports it dropped when full; command flush (2)
// empties the queue and forgets the held frame and the known stream; command tick (1)
// primes until start_threshold frames are queued, then pops frames through the descriptor
// memory, discards late ones, and plays the expected frame or reports silence. Each
// request produces exactly one result, except command 3, which is taken and ignored. An
// arrive, a flush or a priming tick passes the dispatch and finish states to the result;
// any other tick also passes a read state and an event state for each popped frame, the
// descriptor memory read being registered between the two, and then the decide state.
// The input is not ready until the result of the request in flight is placed in the
// output register; that register holds one result while the next request is accepted.
module jitter_buffer_playout_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: src_stream, sequence_req, frame_tag (from bit 0 up)
  input  wire logic [jbp_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: command
  input  wire logic [jbp_pkg::CMD_W-1:0]      in_tuser,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // out_tdata: play_tag, play_stream, play_sequence, late_drops, fill_level (from bit 0 up)
  output logic [jbp_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: event_res
  output logic [jbp_pkg::EV_W-1:0]            out_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_we,
  input  wire logic [jbp_pkg::THR_W-1:0]      cfg_wdata
);
  import jbp_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_POP_RD   = 3'd2;
  localparam logic [2:0] ST_POP_EV   = 3'd3;
  localparam logic [2:0] ST_DECIDE   = 3'd4;
  localparam logic [2:0] ST_FINISH   = 3'd5;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

  // Control state
  logic [2:0]       state_r, state_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             started_r, started_nxt;
  logic             known_r, known_nxt;
  logic             holding_r, holding_nxt;
  logic             first_pop_r, first_pop_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;

  // Payload state
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  jbp_desc_t           item_r, item_nxt;
  jbp_desc_t           held_r, held_nxt;
  logic [STREAM_W-1:0] cur_stream_r, cur_stream_nxt;
  logic [SEQ_W-1:0]    exp_seq_r, exp_seq_nxt;
  logic [LATE_W-1:0]   late_r, late_nxt;
  logic [EV_W-1:0]     res_ev_r, res_ev_nxt;
  logic [TAG_BITS-1:0] res_tag_r, res_tag_nxt;
  logic [STREAM_W-1:0] res_stream_r, res_stream_nxt;
  logic [SEQ_W-1:0]    res_seq_r, res_seq_nxt;
  logic [EV_W-1:0]     out_ev_r, out_ev_nxt;
  logic [TAG_BITS-1:0] out_tag_r, out_tag_nxt;
  logic [STREAM_W-1:0] out_stream_r, out_stream_nxt;
  logic [SEQ_W-1:0]    out_seq_r, out_seq_nxt;
  logic [LATE_W-1:0]   out_late_r, out_late_nxt;
  logic [FILL_W-1:0]   out_fill_r, out_fill_nxt;

  // Descriptor memory
  logic             mem_we, mem_re;
  jbp_desc_t        mem_rdata;
  logic [CNT_W-1:0] thr_sat;
  logic [SEQ_W-1:0] seq_diff;
  logic             in_accept;

  jbp_desc_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr_r),
    .wdata (item_r),
    .re    (mem_re),
    .raddr (rd_ptr_r),
    .rdata (mem_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = OUT_DATA_W'({out_fill_r, out_late_r, out_seq_r, out_stream_r, out_tag_r});

  // Clamp the start threshold to the queue depth
  always_comb begin
    if (int'(thr_r) > QUEUE_DEPTH) begin
      thr_sat = DEPTH_CNT;
    end else begin
      thr_sat = CNT_W'(thr_r);
    end
  end

  // Serial-number distance of the popped frame from the expected slot
  assign seq_diff = mem_rdata.seq - exp_seq_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    count_nxt      = count_r;
    started_nxt    = started_r;
    known_nxt      = known_r;
    holding_nxt    = holding_r;
    first_pop_nxt  = first_pop_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    thr_nxt        = cfg_we ? cfg_wdata : thr_r;
    cmd_nxt        = cmd_r;
    item_nxt       = item_r;
    held_nxt       = held_r;
    cur_stream_nxt = cur_stream_r;
    exp_seq_nxt    = exp_seq_r;
    late_nxt       = late_r;
    res_ev_nxt     = res_ev_r;
    res_tag_nxt    = res_tag_r;
    res_stream_nxt = res_stream_r;
    res_seq_nxt    = res_seq_r;
    out_ev_nxt     = out_ev_r;
    out_tag_nxt    = out_tag_r;
    out_stream_nxt = out_stream_r;
    out_seq_nxt    = out_seq_r;
    out_late_nxt   = out_late_r;
    out_fill_nxt   = out_fill_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // Capture the request
        if (in_accept) begin
          cmd_nxt         = in_tuser;
          item_nxt.stream = in_tdata[STREAM_W-1:0];
          item_nxt.seq    = in_tdata[STREAM_W +: SEQ_W];
          item_nxt.tag    = in_tdata[STREAM_W + SEQ_W +: TAG_BITS];
          state_nxt       = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        late_nxt       = '0;
        res_tag_nxt    = '0;
        res_stream_nxt = '0;
        res_seq_nxt    = '0;
        unique case (cmd_r)
          CMD_ARRIVE: begin
            // Queue the frame unless full
            if (count_r == DEPTH_CNT) begin
              res_ev_nxt = EV_DROPPED;
            end else begin
              mem_we     = 1'b1;
              wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
              count_nxt  = count_r + 1'b1;
              res_ev_nxt = EV_QUEUED;
            end
            state_nxt = ST_FINISH;
          end
          CMD_FLUSH: begin
            rd_ptr_nxt  = '0;
            wr_ptr_nxt  = '0;
            count_nxt   = '0;
            holding_nxt = 1'b0;
            known_nxt   = 1'b0;
            res_ev_nxt  = EV_FLUSHED;
            state_nxt   = ST_FINISH;
          end
          CMD_TICK: begin
            if (!started_r) begin
              // Prime until enough frames are queued
              if (count_r < thr_sat || count_r == '0) begin
                res_ev_nxt = EV_PRIMING;
                state_nxt  = ST_FINISH;
              end else begin
                first_pop_nxt = 1'b1;
                state_nxt     = ST_POP_RD;
              end
            end else if (!holding_r && count_r != '0) begin
              first_pop_nxt = 1'b0;
              state_nxt     = ST_POP_RD;
            end else begin
              state_nxt = ST_DECIDE;
            end
          end
          CMD_RSVD: begin
            // Drop the request without a result
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_POP_RD: begin
        // Read the head entry and advance
        mem_re     = 1'b1;
        rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
        count_nxt  = count_r - 1'b1;
        state_nxt  = ST_POP_EV;
      end

      ST_POP_EV: begin
        held_nxt = mem_rdata;
        priority if (first_pop_r || !known_r || mem_rdata.stream != cur_stream_r) begin
          // Adopt the frame as the start of a stream
          started_nxt    = 1'b1;
          known_nxt      = 1'b1;
          holding_nxt    = 1'b1;
          cur_stream_nxt = mem_rdata.stream;
          exp_seq_nxt    = mem_rdata.seq;
          first_pop_nxt  = 1'b0;
          state_nxt      = ST_DECIDE;
        end else if (!seq_diff[SEQ_W-1]) begin
          holding_nxt = 1'b1;
          state_nxt   = ST_DECIDE;
        end else begin
          // Discard a late frame and keep popping
          late_nxt  = late_r + 1'b1;
          state_nxt = (count_r != '0) ? ST_POP_RD : ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        // Play the held frame or report silence, then advance the slot
        if (holding_r && held_r.stream == cur_stream_r && held_r.seq == exp_seq_r) begin
          res_ev_nxt     = EV_PLAY;
          res_tag_nxt    = held_r.tag;
          res_stream_nxt = held_r.stream;
          holding_nxt    = 1'b0;
        end else begin
          res_ev_nxt     = EV_SILENCE;
          res_stream_nxt = known_r ? cur_stream_r : '0;
        end
        res_seq_nxt = exp_seq_r;
        exp_seq_nxt = exp_seq_r + 1'b1;
        state_nxt   = ST_FINISH;
      end

      ST_FINISH: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_ev_nxt     = res_ev_r;
          out_tag_nxt    = res_tag_r;
          out_stream_nxt = res_stream_r;
          out_seq_nxt    = res_seq_r;
          out_late_nxt   = late_r;
          out_fill_nxt   = FILL_W'(count_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      started_r   <= 1'b0;
      known_r     <= 1'b0;
      holding_r   <= 1'b0;
      first_pop_r <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_W'(3);
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      count_r     <= count_nxt;
      started_r   <= started_nxt;
      known_r     <= known_nxt;
      holding_r   <= holding_nxt;
      first_pop_r <= first_pop_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    item_r       <= item_nxt;
    held_r       <= held_nxt;
    cur_stream_r <= cur_stream_nxt;
    exp_seq_r    <= exp_seq_nxt;
    late_r       <= late_nxt;
    res_ev_r     <= res_ev_nxt;
    res_tag_r    <= res_tag_nxt;
    res_stream_r <= res_stream_nxt;
    res_seq_r    <= res_seq_nxt;
    out_ev_r     <= out_ev_nxt;
    out_tag_r    <= out_tag_nxt;
    out_stream_r <= out_stream_nxt;
    out_seq_r    <= out_seq_nxt;
    out_late_r   <= out_late_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  // Fill count never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("queue fill count above depth");

  // A pop is only issued on a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP_RD |-> count_r != '0)
    else $error("pop from empty queue");

  // Each pop removes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP_RD |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not decrement fill count");

  // A queued frame leaves at least one entry behind
  a_queued_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r == EV_QUEUED |-> out_fill_r != '0)
    else $error("queued result with empty fill level");

  // Late drops never exceed the queue depth
  a_late_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> int'(late_r) <= QUEUE_DEPTH)
    else $error("late drop count above depth");

endmodule

`default_nettype wire

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jbp_pkg::*;

  localparam int RUN_LIMIT     = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 250;

  // Bit offsets of the result fields inside out_tdata
  localparam int OFS_STREAM = TAG_BITS;
  localparam int OFS_SEQ    = OFS_STREAM + STREAM_W;
  localparam int OFS_LATE   = OFS_SEQ + SEQ_W;
  localparam int OFS_FILL   = OFS_LATE + LATE_W;

  typedef struct packed {
    logic [EV_W-1:0]     ev;
    logic [TAG_BITS-1:0] tag;
    logic [STREAM_W-1:0] stream;
    logic [SEQ_W-1:0]    seq;
    logic [LATE_W-1:0]   late;
    logic [FILL_W-1:0]   fill;
  } playout_result_t;

  // Tracks the jitter buffer state and the playout results still owed
  class playout_scoreboard;
    logic [STREAM_W-1:0] q_stream [QUEUE_DEPTH];
    logic [SEQ_W-1:0]    q_seq    [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] q_tag    [QUEUE_DEPTH];
    int                  rd_ptr;
    int                  wr_ptr;
    int                  fill;
    bit                  started;
    bit                  stream_known;
    bit                  holding;
    logic [STREAM_W-1:0] cur_stream;
    logic [SEQ_W-1:0]    want_seq;
    logic [STREAM_W-1:0] held_stream;
    logic [SEQ_W-1:0]    held_seq;
    logic [TAG_BITS-1:0] held_tag;
    int                  threshold;
    int                  errors;
    playout_result_t     owed_q [$];

    function new();
      rd_ptr       = 0;
      wr_ptr       = 0;
      fill         = 0;
      started      = 0;
      stream_known = 0;
      holding      = 0;
      cur_stream   = '0;
      want_seq     = '0;
      held_stream  = '0;
      held_seq     = '0;
      held_tag     = '0;
      threshold    = 3;
      errors       = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Saturate the start threshold at the queue depth
    function void set_threshold(logic [THR_W-1:0] v);
      threshold = (v > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(v);
    endfunction

    function void take_oldest();
      held_stream = q_stream[rd_ptr];
      held_seq    = q_seq[rd_ptr];
      held_tag    = q_tag[rd_ptr];
      rd_ptr      = (rd_ptr + 1) % QUEUE_DEPTH;
      fill--;
    endfunction

    // Advance the buffer state for one accepted request and queue its result
    function void note_request(logic [CMD_W-1:0] cmd, logic [STREAM_W-1:0] sid,
                               logic [SEQ_W-1:0] seq, logic [TAG_BITS-1:0] tag);
      playout_result_t r;
      bit              go;
      logic [SEQ_W-1:0] diff;
      r  = '0;
      go = 1;
      case (cmd)
        CMD_RSVD: return;
        CMD_ARRIVE: begin
          if (fill >= QUEUE_DEPTH) begin
            r.ev = EV_DROPPED;
          end else begin
            q_stream[wr_ptr] = sid;
            q_seq[wr_ptr]    = seq;
            q_tag[wr_ptr]    = tag;
            wr_ptr           = (wr_ptr + 1) % QUEUE_DEPTH;
            fill++;
            r.ev = EV_QUEUED;
          end
        end
        CMD_FLUSH: begin
          rd_ptr       = 0;
          wr_ptr       = 0;
          fill         = 0;
          holding      = 0;
          stream_known = 0;
          r.ev         = EV_FLUSHED;
        end
        default: begin
          // prime until enough frames are queued, then adopt the first one
          if (!started) begin
            if (fill < threshold || fill == 0) begin
              r.ev = EV_PRIMING;
              go   = 0;
            end else begin
              take_oldest();
              started      = 1;
              stream_known = 1;
              holding      = 1;
              cur_stream   = held_stream;
              want_seq     = held_seq;
            end
          end
          if (go) begin
            // pop until a playable frame or a new stream turns up, count late ones
            while (!holding && fill > 0) begin
              take_oldest();
              diff = held_seq - want_seq;
              if (!stream_known || held_stream != cur_stream) begin
                cur_stream   = held_stream;
                want_seq     = held_seq;
                stream_known = 1;
                holding      = 1;
              end else if (!diff[SEQ_W-1]) begin
                holding = 1;
              end else begin
                r.late = r.late + 1'b1;
              end
            end
            if (holding && held_stream == cur_stream && held_seq == want_seq) begin
              r.ev     = EV_PLAY;
              r.tag    = held_tag;
              r.stream = held_stream;
              holding  = 0;
            end else begin
              r.ev     = EV_SILENCE;
              r.stream = stream_known ? cur_stream : '0;
            end
            r.seq    = want_seq;
            want_seq = want_seq + 1'b1;
          end
        end
      endcase
      r.fill = FILL_W'(fill);
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t tb: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one delivered result with the oldest one owed
    function void check_result(logic [EV_W-1:0] ev, logic [OUT_DATA_W-1:0] data);
      playout_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t tb: unexpected result, event %0d data %0h", $time, ev, data);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("event_res", 32'(want.ev), 32'(ev));
      compare_field("play_tag", 32'(want.tag), 32'(data[TAG_BITS-1:0]));
      compare_field("play_stream", want.stream, data[OFS_STREAM +: STREAM_W]);
      compare_field("play_sequence", want.seq, data[OFS_SEQ +: SEQ_W]);
      compare_field("late_drops", 32'(want.late), 32'(data[OFS_LATE +: LATE_W]));
      compare_field("fill_level", 32'(want.fill), 32'(data[OFS_FILL +: FILL_W]));
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [EV_W-1:0]       out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [THR_W-1:0]      cfg_wdata  = '0;

  bit                  tx_idle_on = 1'b1;
  bit                  rx_idle_on = 1'b1;
  bit                  hold_long  = 1'b0;
  int                  cycle_count = 0;
  logic [STREAM_W-1:0] cur_sid;
  logic [SEQ_W-1:0]    next_seq;

  playout_scoreboard sb = new();

  jitter_buffer_playout_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watch both handshakes at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready)
        sb.note_request(in_tuser, in_tdata[STREAM_W-1:0], in_tdata[STREAM_W +: SEQ_W],
                        in_tdata[STREAM_W+SEQ_W +: TAG_BITS]);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until taken
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [STREAM_W-1:0] sid,
                          input logic [SEQ_W-1:0] seq, input logic [TAG_BITS-1:0] tag);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_W'({tag, seq, sid});
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every owed result is delivered
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    // let the request taken at this edge reach the scoreboard first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_threshold(v);
  endtask

  // Mostly in-order frames of one stream with jitter, plus ticks and noise
  task automatic send_random_item(input int arrive_pct, output bit counted);
    int                  p;
    int                  j;
    logic [STREAM_W-1:0] sid;
    logic [SEQ_W-1:0]    seq;
    p       = $urandom_range(0, 99);
    sid     = cur_sid;
    seq     = next_seq;
    counted = 1'b1;
    if (p < 3) begin
      // switch to a new stream without a flush
      cur_sid  = $urandom;
      next_seq = $urandom;
      seq      = next_seq;
      next_seq = next_seq + 1'b1;
      send_req(CMD_ARRIVE, cur_sid, seq, TAG_BITS'($urandom));
    end else if (p < 3 + arrive_pct) begin
      j = $urandom_range(0, 19);
      if (j < 13) begin
        next_seq = next_seq + 1'b1;
      end else if (j < 16) begin
        seq = next_seq - SEQ_W'($urandom_range(1, 6));
      end else if (j < 18) begin
        next_seq = next_seq + SEQ_W'($urandom_range(1, 2));
        seq      = next_seq;
        next_seq = next_seq + 1'b1;
      end else if (j == 18) begin
        seq = $urandom;
      end else begin
        sid = $urandom;
      end
      send_req(CMD_ARRIVE, sid, seq, TAG_BITS'($urandom));
    end else if (p < 96) begin
      send_req(CMD_TICK, $urandom, $urandom, TAG_BITS'($urandom));
    end else if (p < 98) begin
      send_req(CMD_FLUSH, $urandom, $urandom, TAG_BITS'($urandom));
    end else begin
      send_req(CMD_RSVD, $urandom, $urandom, TAG_BITS'($urandom));
      counted = 1'b0;
    end
  endtask

  initial begin
    int               ph;
    int               sent;
    int               k;
    bit               counted;
    int               arrive_mix [5];
    logic [THR_W-1:0] thr_plan   [5];
    arrive_mix = '{45, 60, 40, 50, 45};
    thr_plan   = '{4'd8, 4'd1, 4'd15, 4'd0, 4'($urandom_range(0, 15))};
    cur_sid    = $urandom;
    next_seq   = $urandom;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Priming at the reset threshold, then the reserved command
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_RSVD, '1, '1, '1);

    // Threshold zero with an empty queue still primes
    write_threshold(4'd0);
    send_req(CMD_TICK, '0, '0, '0);

    // Threshold above the depth saturates; three frames are not enough
    write_threshold(4'd15);
    send_req(CMD_ARRIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'hFF);
    send_req(CMD_ARRIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
    send_req(CMD_ARRIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 8'h12);
    send_req(CMD_TICK, '0, '0, '0);

    // Start playout, wrap the sequence, discard a late frame, underrun on a gap
    write_threshold(4'd3);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_ARRIVE, 32'hFFFF_FFFF, 32'h0000_0000, 8'h5A);
    send_req(CMD_ARRIVE, 32'hFFFF_FFFF, 32'h0000_0003, 8'h01);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_TICK, '0, '0, '0);

    // Adopt a new stream without a flush
    send_req(CMD_ARRIVE, 32'h0000_0000, 32'h8000_0000, 8'h80);
    send_req(CMD_TICK, '0, '0, '0);

    // Flush, then silence with no known stream
    send_req(CMD_FLUSH, '0, '0, '0);
    send_req(CMD_TICK, '0, '0, '0);

    // Fill the queue and drop one frame, then play from a full queue
    for (k = 0; k < QUEUE_DEPTH + 1; k++)
      send_req(CMD_ARRIVE, 32'h0000_5A5A, 32'(k) * 32'h1111_1111, TAG_BITS'(k * 29));
    send_req(CMD_TICK, '0, '0, '0);

    // Random phases; the second one holds results off for a long stretch
    for (ph = 0; ph < 5; ph++) begin
      write_threshold(thr_plan[ph]);
      tx_idle_on = (ph < 4);
      rx_idle_on = (ph < 4);
      if (ph == 1) hold_long = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_item(arrive_mix[ph], counted);
        if (counted) sent++;
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
